/* sv/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;

    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;
    localparam int CAP_BITS      = 5;

    localparam logic [CAP_BITS-1:0]      CAP_RESET        = 5'd16;
    localparam logic [APB_ADDR_BITS-1:0] REG_CAPACITY_ADR = 2'd0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic key_we;
        logic value_we;
        logic rank_we;
    } slot_wr_t;

endpackage

`default_nettype wire

/* sv/lkvc_slot_mem.sv */
// ----------------------------------------------------------------------------
// lkvc_slot_mem
// Slot storage: key, value and recency rank memories, one read port with
// registered data and one write port with per-field enables.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_slot_mem #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS,
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire                     aclk,
    input  wire  [IDX_W-1:0]        rd_addr,
    output logic [KEY_BITS-1:0]     rd_key,
    output logic [VALUE_BITS-1:0]   rd_value,
    output logic [IDX_W-1:0]        rd_rank,
    input  lkvc_pkg::slot_wr_t      wr,
    input  wire  [IDX_W-1:0]        wr_addr,
    input  wire  [KEY_BITS-1:0]     wr_key,
    input  wire  [VALUE_BITS-1:0]   wr_value,
    input  wire  [IDX_W-1:0]        wr_rank
);

    logic [KEY_BITS-1:0]   key_mem   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_mem  [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr.key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr.value_we) begin
            value_mem[wr_addr] <= wr_value;
        end
        if (wr.rank_we) begin
            rank_mem[wr_addr] <= wr_rank;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
        rd_rank  <= rank_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* sv/lru_key_value_cache_unit.sv */
// A get miss takes one scan sweep over the slots, a hit or a put a scan and a rank-update sweep;
// a result still waiting holds the next one back.
// One request at a time: the next is accepted in the cycle after the result is loaded.
// Each sweep reads one slot per cycle.
// Reset: synchronous, active low; clears all valid bits and the fill count and
// sets the capacity register to 16. Slot memories are not cleared.
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement,
// driven by a sequencer over a slot memory with one read port and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS,
    localparam int TDATA_W    = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // apb
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [lkvc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire  [lkvc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    // request stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [TDATA_W-1:0]                   s_axis_tdata,  // lookup_key, write_value
    input  wire  [0:0]                           s_axis_tuser,  // operation
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [TDATA_W-1:0]                   m_axis_tdata,  // read_value, evicted_key
    output logic [1:0]                           m_axis_tuser   // hit, evicted
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ENTRIES);

    lkvc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic                      chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]          chk_idx_reg, chk_idx_next;

    logic                      op_reg, op_next;
    logic [KEY_BITS-1:0]       key_reg, key_next;
    logic [VALUE_BITS-1:0]     wval_reg, wval_next;

    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          found_idx_reg, found_idx_next;
    logic [IDX_W-1:0]          found_rank_reg, found_rank_next;
    logic [VALUE_BITS-1:0]     found_value_reg, found_value_next;
    logic                      old_any_reg, old_any_next;
    logic [IDX_W-1:0]          old_idx_reg, old_idx_next;
    logic [IDX_W-1:0]          old_rank_reg, old_rank_next;
    logic [KEY_BITS-1:0]       old_key_reg, old_key_next;
    logic                      free_any_reg, free_any_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;

    logic [IDX_W-1:0]          tgt_idx_reg, tgt_idx_next;
    logic [IDX_W-1:0]          limit_reg, limit_next;
    logic                      inc_all_reg, inc_all_next;

    logic [MAX_ENTRIES-1:0]    slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [lkvc_pkg::CAP_BITS-1:0] cap_reg;
    logic [CNT_W-1:0]          cap_eff;

    logic                      res_hit_reg, res_hit_next;
    logic [VALUE_BITS-1:0]     res_val_reg, res_val_next;
    logic                      res_ev_reg, res_ev_next;
    logic [KEY_BITS-1:0]       res_evkey_reg, res_evkey_next;

    logic                      m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0]        m_data_reg, m_data_next;
    logic [1:0]                m_user_reg, m_user_next;

    logic [IDX_W-1:0]          rd_addr;
    logic [KEY_BITS-1:0]       rd_key;
    logic [VALUE_BITS-1:0]     rd_value;
    logic [IDX_W-1:0]          rd_rank;
    lkvc_pkg::slot_wr_t        mem_wr;
    logic [IDX_W-1:0]          mem_wr_addr;
    logic [KEY_BITS-1:0]       mem_wr_key;
    logic [VALUE_BITS-1:0]     mem_wr_value;
    logic [IDX_W-1:0]          mem_wr_rank;

    logic                      cfg_wr;

    lkvc_slot_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_slot_mem (
        .aclk     (aclk),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_rank  (rd_rank),
        .wr       (mem_wr),
        .wr_addr  (mem_wr_addr),
        .wr_key   (mem_wr_key),
        .wr_value (mem_wr_value),
        .wr_rank  (mem_wr_rank)
    );

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == lkvc_pkg::REG_CAPACITY_ADR);

    always_comb begin
        if (paddr == lkvc_pkg::REG_CAPACITY_ADR) begin
            prdata = lkvc_pkg::APB_DATA_BITS'(cap_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[lkvc_pkg::CAP_BITS-1:0];
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(cap_reg) > MAX_ENTRIES) begin
            cap_eff = LAST_CNT;
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign s_axis_tready = (state_reg == lkvc_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign rd_addr       = scan_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lkvc_pkg::ST_IDLE;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        chk_idx_reg     <= chk_idx_next;
        op_reg          <= op_next;
        key_reg         <= key_next;
        wval_reg        <= wval_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        found_rank_reg  <= found_rank_next;
        found_value_reg <= found_value_next;
        old_any_reg     <= old_any_next;
        old_idx_reg     <= old_idx_next;
        old_rank_reg    <= old_rank_next;
        old_key_reg     <= old_key_next;
        free_any_reg    <= free_any_next;
        free_idx_reg    <= free_idx_next;
        tgt_idx_reg     <= tgt_idx_next;
        limit_reg       <= limit_next;
        inc_all_reg     <= inc_all_next;
        res_hit_reg     <= res_hit_next;
        res_val_reg     <= res_val_next;
        res_ev_reg      <= res_ev_next;
        res_evkey_reg   <= res_evkey_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
    end

    always_comb begin
        logic             issue;
        logic             evict;
        logic [IDX_W-1:0] fill_idx;

        state_next       = state_reg;
        scan_next        = scan_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        wval_next        = wval_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        found_rank_next  = found_rank_reg;
        found_value_next = found_value_reg;
        old_any_next     = old_any_reg;
        old_idx_next     = old_idx_reg;
        old_rank_next    = old_rank_reg;
        old_key_next     = old_key_reg;
        free_any_next    = free_any_reg;
        free_idx_next    = free_idx_reg;
        tgt_idx_next     = tgt_idx_reg;
        limit_next       = limit_reg;
        inc_all_next     = inc_all_reg;
        slot_valid_next  = slot_valid_reg;
        count_next       = count_reg;
        res_hit_next     = res_hit_reg;
        res_val_next     = res_val_reg;
        res_ev_next      = res_ev_reg;
        res_evkey_next   = res_evkey_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;
        mem_wr           = '0;
        mem_wr_addr      = chk_idx_reg;
        mem_wr_key       = key_reg;
        mem_wr_value     = wval_reg;
        mem_wr_rank      = '0;
        issue            = (scan_reg != LAST_CNT);
        evict            = 1'b0;
        fill_idx         = free_idx_reg;

        unique case (state_reg)
            lkvc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next       = s_axis_tuser[0];
                    key_next      = s_axis_tdata[KEY_BITS-1:0];
                    wval_next     = s_axis_tdata[KEY_BITS +: VALUE_BITS];
                    scan_next     = '0;
                    found_next    = 1'b0;
                    old_any_next  = 1'b0;
                    free_any_next = 1'b0;
                    state_next    = lkvc_pkg::ST_SCAN;
                end
            end

            lkvc_pkg::ST_SCAN: begin
                if (issue) begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                end
                if (chk_valid_reg) begin
                    if (slot_valid_reg[chk_idx_reg]) begin
                        if (!found_reg && rd_key == key_reg) begin
                            found_next       = 1'b1;
                            found_idx_next   = chk_idx_reg;
                            found_rank_next  = rd_rank;
                            found_value_next = rd_value;
                        end
                        if (!old_any_reg || rd_rank > old_rank_reg) begin
                            old_any_next  = 1'b1;
                            old_idx_next  = chk_idx_reg;
                            old_rank_next = rd_rank;
                            old_key_next  = rd_key;
                        end
                    end else if (!free_any_reg) begin
                        free_any_next = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
                if (!issue && !chk_valid_reg) begin
                    scan_next      = '0;
                    res_hit_next   = 1'b0;
                    res_val_next   = '0;
                    res_ev_next    = 1'b0;
                    res_evkey_next = '0;
                    priority if (found_reg) begin
                        mem_wr.rank_we  = 1'b1;
                        mem_wr.value_we = (op_reg == lkvc_pkg::OP_PUT);
                        mem_wr_addr     = found_idx_reg;
                        tgt_idx_next    = found_idx_reg;
                        limit_next      = found_rank_reg;
                        inc_all_next    = 1'b0;
                        res_hit_next    = 1'b1;
                        if (op_reg == lkvc_pkg::OP_GET) begin
                            res_val_next = found_value_reg;
                        end
                        state_next = lkvc_pkg::ST_UPDATE;
                    end else if (op_reg == lkvc_pkg::OP_PUT) begin
                        evict = (count_reg >= cap_eff) && old_any_reg;
                        if (evict) begin
                            if (!free_any_reg || old_idx_reg < free_idx_reg) begin
                                fill_idx = old_idx_reg;
                            end
                            slot_valid_next[old_idx_reg] = 1'b0;
                            res_ev_next    = 1'b1;
                            res_evkey_next = old_key_reg;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        slot_valid_next[fill_idx] = 1'b1;
                        mem_wr.key_we   = 1'b1;
                        mem_wr.value_we = 1'b1;
                        mem_wr.rank_we  = 1'b1;
                        mem_wr_addr     = fill_idx;
                        tgt_idx_next    = fill_idx;
                        inc_all_next    = 1'b1;
                        state_next      = lkvc_pkg::ST_UPDATE;
                    end else begin
                        state_next = lkvc_pkg::ST_DONE;
                    end
                end
            end

            lkvc_pkg::ST_UPDATE: begin
                if (issue) begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                end
                if (chk_valid_reg && slot_valid_reg[chk_idx_reg]
                    && chk_idx_reg != tgt_idx_reg
                    && (inc_all_reg || rd_rank < limit_reg)) begin
                    mem_wr.rank_we = 1'b1;
                    mem_wr_addr    = chk_idx_reg;
                    mem_wr_rank    = rd_rank + 1'b1;
                end
                if (!issue && !chk_valid_reg) begin
                    state_next = lkvc_pkg::ST_DONE;
                end
            end

            lkvc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = TDATA_W'({res_evkey_reg, res_val_reg});
                    m_user_next  = {res_ev_reg, res_hit_reg};
                    state_next   = lkvc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_valid_reg) == int'(count_reg))
        else $error("fill count disagrees with valid bits");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_ENTRIES)
        else $error("fill count above slot count");

    a_evict_not_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[1] |-> !m_user_reg[0])
        else $error("eviction reported together with hit");

    a_update_needs_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lkvc_pkg::ST_UPDATE |-> (found_reg || op_reg == lkvc_pkg::OP_PUT))
        else $error("rank sweep after a get miss");

    a_get_miss_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == lkvc_pkg::ST_SCAN && state_reg == lkvc_pkg::ST_DONE
        |-> slot_valid_reg == $past(slot_valid_reg))
        else $error("get miss changed slot occupancy");

endmodule

`default_nettype wire

/* bench/lru_key_value_cache_unit_tb.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Self-checking bench for the LRU key-value cache. A behavioral copy of the
// cache predicts hit, read value and eviction for every accepted request.
// Directed requests cover the edge cases, then random get/put traffic runs
// over shifting key pools and capacities, with source and sink throttling
// varied per phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit_tb;

    import lkvc_pkg::*;

    localparam int TDATA_W     = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * MAX_ENTRIES + 8;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } cache_result_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_DATA_BITS-1:0]  pwdata        = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [TDATA_W-1:0]        s_axis_tdata  = '0;  // lookup_key, write_value
    logic [0:0]                s_axis_tuser  = '0;  // operation
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]        m_axis_tdata;        // read_value, evicted_key
    logic [1:0]                m_axis_tuser;        // hit, evicted

    // cache shadow
    logic [CAP_BITS-1:0]   capacity_reg;
    logic                  shadow_valid [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   shadow_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] shadow_value [MAX_ENTRIES];
    int                    shadow_rank  [MAX_ENTRIES];
    int                    shadow_count;

    cache_result_t         pending_results [$];
    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
    int                    pool_span;
    int                    sender_idle_pct   = 0;
    int                    receiver_stall_pct = 0;
    int                    error_count = 0;
    int                    cycle_count = 0;

    lru_key_value_cache_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void age_slots(int s, int limit);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (shadow_valid[i] && i != s && shadow_rank[i] < limit)
                shadow_rank[i] = shadow_rank[i] + 1;
        end
        shadow_rank[s] = 0;
    endfunction

    function automatic cache_result_t predict_access(logic op, logic [KEY_BITS-1:0] key,
                                                     logic [VALUE_BITS-1:0] val);
        cache_result_t r;
        int            cap;
        int            found;
        int            oldest;
        int            free_slot;
        r = '0;
        cap = int'(capacity_reg);
        if (cap < 1)
            cap = 1;
        if (cap > MAX_ENTRIES)
            cap = MAX_ENTRIES;
        found = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
                found = i;
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            if (op == OP_GET)
                r.read_value = shadow_value[found];
            else
                shadow_value[found] = val;
            age_slots(found, shadow_rank[found]);
        end else if (op == OP_PUT) begin
            if (shadow_count >= cap) begin
                oldest = -1;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (shadow_valid[i] &&
                        (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                        oldest = i;
                end
                if (oldest >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = shadow_key[oldest];
                    shadow_valid[oldest] = 1'b0;
                    shadow_count = shadow_count - 1;
                end
            end
            free_slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (free_slot < 0 && !shadow_valid[i])
                    free_slot = i;
            end
            if (free_slot >= 0) begin
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot] = key;
                shadow_value[free_slot] = val;
                age_slots(free_slot, MAX_ENTRIES);
                shadow_count = shadow_count + 1;
            end
        end
        return r;
    endfunction

    // result sink: throttle tready, compare each accepted result
    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn) begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser[0] !== want.hit) begin
                        $error("hit: expected %0h, got %0h", want.hit, m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[VALUE_BITS-1:0] !== want.read_value) begin
                        $error("read_value: expected %0h, got %0h", want.read_value,
                               m_axis_tdata[VALUE_BITS-1:0]);
                        error_count++;
                    end
                    if (m_axis_tuser[1] !== want.evicted) begin
                        $error("evicted: expected %0h, got %0h", want.evicted,
                               m_axis_tuser[1]);
                        error_count++;
                    end
                    if (m_axis_tdata[VALUE_BITS +: KEY_BITS] !== want.evicted_key) begin
                        $error("evicted_key: expected %0h, got %0h", want.evicted_key,
                               m_axis_tdata[VALUE_BITS +: KEY_BITS]);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic send_request(logic op, logic [KEY_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] val);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({val, key});
        s_axis_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        pending_results.push_back(predict_access(op, key, val));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic read_capacity(logic [CAP_BITS-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_CAPACITY_ADR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_BITS'(want)) begin
            $error("capacity_in_use: expected %0h, got %0h", want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(logic [CAP_BITS-1:0] cap);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY_ADR;
        pwdata  <= APB_DATA_BITS'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        capacity_reg = cap;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        read_capacity(cap);
    endtask

    task automatic test_reset_state();
        read_capacity(CAP_RESET);
    endtask

    task automatic test_directed();
        send_request(OP_GET, 16'h0000, 32'hFFFF_FFFF);
        send_request(OP_PUT, 16'h0000, 32'h0000_0000);
        send_request(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 16'hFFFF, 32'h0000_0000);
        send_request(OP_GET, 16'h0000, 32'hA5A5_A5A5);
        send_request(OP_PUT, 16'hFFFF, 32'h1234_5678);
        send_request(OP_GET, 16'hFFFF, 32'h0);
        send_request(OP_GET, 16'h1234, 32'h0);
        set_capacity(5'd2);
        send_request(OP_PUT, 16'h0001, 32'h0000_0001);
        send_request(OP_GET, 16'h0000, 32'h0);
        set_capacity(5'd0);
        send_request(OP_PUT, 16'h0002, 32'h8000_0000);
        send_request(OP_PUT, 16'h0003, 32'h7FFF_FFFF);
        send_request(OP_GET, 16'h0002, 32'h0);
        send_request(OP_GET, 16'h0003, 32'h0);
        set_capacity(5'd31);
        for (int i = 0; i < 16; i++)
            send_request(OP_PUT, 16'(16'h0100 + i), $urandom);
        send_request(OP_GET, 16'h0003, 32'h0);
        set_capacity(5'd17);
        send_request(OP_PUT, 16'h5555, 32'h5555_5555);
        set_capacity(5'd1);
        send_request(OP_PUT, 16'hAAAA, 32'hAAAA_AAAA);
        send_request(OP_GET, 16'hAAAA, 32'h0);
        wait_drained();
    endtask

    task automatic run_random_block(int count, logic [CAP_BITS-1:0] cap);
        logic [KEY_BITS-1:0]   key;
        logic                  op;
        set_capacity(cap);
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = 16'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        pool_span = $urandom_range(1, POOL_SIZE - 1);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, pool_span)];
            else
                key = 16'($urandom);
            op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            send_request(op, key, $urandom);
            if (i == count / 2 && $urandom_range(0, 1))
                wait_drained();
        end
    endtask

    task automatic run_random_phase();
        run_random_block(88, 5'd16);
        run_random_block(88, 5'd1);
        run_random_block(88, 5'($urandom_range(2, 15)));
        run_random_block(88, 5'($urandom_range(0, 31)));
    endtask

    task automatic test_no_idle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_random_phase();
    endtask

    task automatic test_sender_idle();
        sender_idle_pct = 88;
        receiver_stall_pct = 0;
        run_random_phase();
    endtask

    task automatic test_receiver_stall();
        sender_idle_pct = 0;
        receiver_stall_pct = 88;
        run_random_phase();
    endtask

    task automatic test_both_idle();
        sender_idle_pct = 33;
        receiver_stall_pct = 33;
        run_random_phase();
    endtask

    initial begin
        capacity_reg = CAP_RESET;
        shadow_count = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
